// File: src/bitmap_page_allocator_unit_assert.svh
// Assertion macros for the bitmap page allocator.
`ifndef BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/bpa_pkg.sv
// Shared constants, types and helpers of the bitmap page allocator.
package bpa_pkg;

    localparam int NUM_PAGES = 32768;
    localparam int NUM_BYTES = (NUM_PAGES + 7) / 8;
    localparam int IDX_W     = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
    localparam int HINT_W    = $clog2(NUM_BYTES + 1);
    localparam int PAGE_W    = IDX_W + 3;
    localparam int FRAME_W   = 20;
    localparam int REM_BITS  = NUM_PAGES % 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] LAST_FILL = (REM_BITS == 0) ? 8'hFF : 8'((1 << REM_BITS) - 1);
    localparam logic [FRAME_W-1:0] CEIL_RESET = 20'd32768;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_PAGE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING_PAGE = 2'd1;

    typedef logic [FRAME_W-1:0] t_frame;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [IDX_W-1:0] addr;
        logic [7:0]       wdata;
    } t_ram_req;

    // lowest set bit, 7 when none
    function automatic logic [2:0] lowest_bit(input logic [7:0] b);
        logic [2:0] p;
        p = 3'd7;
        for (int i = 7; i >= 0; i--) begin
            if (b[i]) begin
                p = 3'(i);
            end
        end
        return p;
    endfunction

endpackage

// File: src/bpa_if.sv
// Request, response and configuration channel interfaces.
interface bpa_req_if import bpa_pkg::*;;
    logic   valid;
    logic   ready;
    logic   kind;
    t_frame frame;
    modport source (output valid, output kind, output frame, input ready);
    modport sink (input valid, input kind, input frame, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*;;
    logic    valid;
    logic    ready;
    t_frame  granted_frame;
    t_status status;
    modport source (output valid, output granted_frame, output status, input ready);
    modport sink (input valid, input granted_frame, input status, output ready);
endinterface

interface bpa_cfg_if import bpa_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_frame               data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/bpa_bitmap_ram.sv
// Free bitmap store: one write or read port, registered read data.
module bpa_bitmap_ram import bpa_pkg::*; (
    input  logic     i_clk,
    input  t_ram_req i_req,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [NUM_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/bitmap_page_allocator_unit.sv
// Top level of the first-fit bitmap page allocator.
// Channels: i_req carries allocate (kind 0) or free (kind 1, with frame) requests,
// o_rsp returns one response per request (granted_frame, status), and i_cfg
// writes base_page (index 0) or ceiling_page (index 1); other indexes are ignored.
// After reset the bitmap store is filled with free bits, one byte a cycle,
// over all NUM_BYTES (4096) bytes; i_req.ready stays low meanwhile, i_cfg is always ready.
// One request at a time. An out-of-range free or an allocate on an empty bitmap
// answers at the accepting edge. A free reads its byte, then sets the bit in it.
// An allocate reads the hint byte and clears its lowest set bit below the ceiling;
// the hint is then moved on by reading and testing byte after byte over the single
// store port. Its response is registered from the check state; the scan runs on.
// The response sits in an output register; a new request is taken while it is
// being drained, and a stalled receiver holds the block in idle.
`include "bitmap_page_allocator_unit_assert.svh"

module bitmap_page_allocator_unit import bpa_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bpa_req_if.sink        i_req,
    bpa_rsp_if.source      o_rsp,
    bpa_cfg_if.sink        i_cfg
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACHK,
        S_FWR,
        S_SCAN_RD,
        S_SCAN_CHK
    } t_state;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_BYTES - 1);
    localparam logic [HINT_W-1:0] HINT_END  = HINT_W'(NUM_BYTES);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_clr, n_clr;
    logic [HINT_W-1:0] r_hint, n_hint;
    t_frame            r_base, n_base;
    t_frame            r_ceil, n_ceil;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [2:0]        r_bit, n_bit;
    logic              r_out_valid, n_out_valid;
    t_frame            r_out_frame, n_out_frame;
    t_status           r_out_status, n_out_status;

    t_ram_req          ram_req;
    logic [7:0]        ram_rdata;
    logic              req_acc;
    logic              out_load;
    logic [HINT_W-1:0] hint_inc;
    logic [FRAME_W:0]  diff;
    logic              range_bad;
    logic [2:0]        pos;
    logic [FRAME_W:0]  f_sum;
    logic [7:0]        cleared;

    bpa_bitmap_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign i_cfg.ready = 1'b1;
    assign req_acc     = i_req.valid && i_req.ready;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.granted_frame = r_out_frame;
    assign o_rsp.status        = r_out_status;

    assign hint_inc  = r_hint + 1'b1;
    assign diff      = {1'b0, i_req.frame} - {1'b0, r_base};
    assign range_bad = diff[FRAME_W] || (diff >= (FRAME_W+1)'(NUM_PAGES));
    assign pos       = lowest_bit(ram_rdata);
    assign f_sum     = {1'b0, r_base} + (FRAME_W+1)'({r_hint[IDX_W-1:0], pos});
    assign cleared   = ram_rdata & ~(8'b1 << pos);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_hint       = r_hint;
        n_base       = r_base;
        n_ceil       = r_ceil;
        n_idx        = r_idx;
        n_bit        = r_bit;
        n_out_frame  = r_out_frame;
        n_out_status = r_out_status;
        out_load     = 1'b0;
        ram_req      = '0;

        case (r_state)
            S_CLEAR: begin
                ram_req.we    = 1'b1;
                ram_req.addr  = r_clr;
                ram_req.wdata = (r_clr == LAST_IDX) ? LAST_FILL : 8'hFF;
                n_hint        = '0;
                if (r_clr == LAST_IDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (req_acc) begin
                    if (i_req.kind == KIND_ALLOC) begin
                        if (r_hint >= HINT_END) begin
                            out_load     = 1'b1;
                            n_out_frame  = '0;
                            n_out_status = ST_NONE;
                        end else begin
                            ram_req.re   = 1'b1;
                            ram_req.addr = r_hint[IDX_W-1:0];
                            n_state      = S_ACHK;
                        end
                    end else if (range_bad) begin
                        out_load     = 1'b1;
                        n_out_frame  = '0;
                        n_out_status = ST_RANGE;
                    end else begin
                        ram_req.re   = 1'b1;
                        ram_req.addr = diff[PAGE_W-1:3];
                        n_idx        = diff[PAGE_W-1:3];
                        n_bit        = diff[2:0];
                        n_state      = S_FWR;
                    end
                end
            end
            S_ACHK: begin
                out_load = 1'b1;
                if (f_sum >= {1'b0, r_ceil}) begin
                    n_out_frame  = '0;
                    n_out_status = ST_NONE;
                    n_state      = S_IDLE;
                end else begin
                    ram_req.we    = 1'b1;
                    ram_req.addr  = r_hint[IDX_W-1:0];
                    ram_req.wdata = cleared;
                    n_out_frame   = f_sum[FRAME_W-1:0];
                    n_out_status  = ST_OK;
                    if (cleared != 8'h00) begin
                        n_state = S_IDLE;
                    end else begin
                        n_hint  = hint_inc;
                        n_state = (hint_inc == HINT_END) ? S_IDLE : S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                ram_req.re   = 1'b1;
                ram_req.addr = r_hint[IDX_W-1:0];
                n_state      = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (ram_rdata != 8'h00) begin
                    n_state = S_IDLE;
                end else begin
                    n_hint  = hint_inc;
                    n_state = (hint_inc == HINT_END) ? S_IDLE : S_SCAN_RD;
                end
            end
            S_FWR: begin
                ram_req.we    = 1'b1;
                ram_req.addr  = r_idx;
                ram_req.wdata = ram_rdata | (8'b1 << r_bit);
                if (HINT_W'(r_idx) < r_hint) begin
                    n_hint = HINT_W'(r_idx);
                end
                out_load     = 1'b1;
                n_out_frame  = '0;
                n_out_status = ST_OK;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_BASE_PAGE:    n_base = i_cfg.data;
                REG_CEILING_PAGE: n_ceil = i_cfg.data;
                default: ;
            endcase
        end

        n_out_valid = out_load || (r_out_valid && !o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_hint      <= '0;
            r_base      <= '0;
            r_ceil      <= CEIL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_hint       <= n_hint;
            r_base       <= n_base;
            r_ceil       <= n_ceil;
            r_out_valid  <= n_out_valid;
            r_idx        <= n_idx;
            r_bit        <= n_bit;
            r_out_frame  <= n_out_frame;
            r_out_status <= n_out_status;
        end
    end

    `BPA_ASSERT_IMP(a_hint_range, i_clk, i_rst_n, 1'b1, r_hint <= HINT_END, "hint past end")
    `BPA_ASSERT_IMP(a_out_slot, i_clk, i_rst_n, out_load, !r_out_valid || o_rsp.ready, "rsp lost")
    `BPA_ASSERT_IMP(a_clear_hint, i_clk, i_rst_n, r_state == S_CLEAR, r_hint == '0, "hint moved")
    `BPA_ASSERT_NXT(a_alloc_rd, i_clk, i_rst_n,
        req_acc && (i_req.kind == KIND_ALLOC) && (r_hint < HINT_END), r_state == S_ACHK, "alloc lost")

endmodule

// File: tb/sv/bitmap_page_allocator_unit_test.sv
// Self-checking testbench of the first-fit bitmap page allocator, predicted in step.
module bitmap_page_allocator_unit_test;
    import bpa_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam logic [HINT_W-1:0]    HINT_END    = HINT_W'(NUM_BYTES);

    typedef struct packed {
        t_frame  granted_frame;
        t_status status;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();
    bpa_cfg_if cfg_ch ();

    bitmap_page_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // predicted allocator state
    bit [7:0]          page_map [NUM_BYTES];
    logic [HINT_W-1:0] first_free_byte;
    t_frame            base_reg;
    t_frame            ceiling_reg;
    t_frame            held_frames [$];
    t_answer           awaited_answers [$];

    int unsigned gap_pct        = 0;
    int unsigned stall_pct      = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          req_up;

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // response side: check against the oldest awaited answer, stall at random
    always @(posedge i_clk) begin : rsp_check
        t_answer want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_answers.size() == 0) begin
                flag_mismatch($sformatf("unexpected response frame %h status %0d",
                                        rsp_ch.granted_frame, rsp_ch.status));
            end else begin
                want = awaited_answers.pop_front();
                if (rsp_ch.granted_frame !== want.granted_frame) begin
                    flag_mismatch($sformatf("granted_frame %h, want %h",
                                            rsp_ch.granted_frame, want.granted_frame));
                end
                if (rsp_ch.status !== want.status) begin
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            rsp_ch.status, want.status));
                end
            end
        end
        rsp_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    task automatic model_reset();
        for (int i = 0; i < NUM_BYTES; i++) begin
            page_map[i] = 8'hFF;
        end
        page_map[NUM_BYTES-1] = LAST_FILL;
        first_free_byte = '0;
        base_reg        = '0;
        ceiling_reg     = CEIL_RESET;
    endtask

    task automatic predict(input logic kind, input t_frame frame, output t_answer ans);
        logic [2:0]       pos;
        logic [FRAME_W:0] f;
        logic [31:0]      page;
        logic [IDX_W-1:0] idx;
        ans.granted_frame = '0;
        ans.status        = ST_OK;
        if (kind == KIND_ALLOC) begin
            if (first_free_byte >= HINT_END) begin
                ans.status = ST_NONE;
            end else begin
                idx = first_free_byte[IDX_W-1:0];
                pos = lowest_bit(page_map[idx]);
                f   = {1'b0, base_reg} + (FRAME_W+1)'({idx, pos});
                if (f >= {1'b0, ceiling_reg}) begin
                    ans.status = ST_NONE;
                end else begin
                    page_map[idx][pos] = 1'b0;
                    while (first_free_byte < HINT_END &&
                           page_map[first_free_byte[IDX_W-1:0]] == 8'h00) begin
                        first_free_byte++;
                    end
                    ans.granted_frame = f[FRAME_W-1:0];
                    held_frames.push_back(f[FRAME_W-1:0]);
                end
            end
        end else if (frame < base_reg || (32'(frame) - 32'(base_reg)) >= 32'(NUM_PAGES)) begin
            ans.status = ST_RANGE;
        end else begin
            page = 32'(frame) - 32'(base_reg);
            idx  = page[PAGE_W-1:3];
            page_map[idx][page[2:0]] = 1'b1;
            if (HINT_W'(idx) < first_free_byte) begin
                first_free_byte = HINT_W'(idx);
            end
        end
    endtask

    task automatic set_phase(input int unsigned gap, input int unsigned stall);
        gap_pct   = gap;
        stall_pct = stall;
    endtask

    task automatic drive_idle();
        if (req_up) begin
            req_ch.valid <= 1'b0;
            req_up = 1'b0;
        end
    endtask

    task automatic send_req(input logic kind, input t_frame frame);
        t_answer ans;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            drive_idle();
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.frame <= frame;
        req_up = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        predict(kind, frame, ans);
        awaited_answers.push_back(ans);
    endtask

    // pause until every awaited response is back and the block is idle
    task automatic wait_drain();
        drive_idle();
        do @(posedge i_clk); while (awaited_answers.size() != 0 || !req_ch.ready);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] index, input t_frame data);
        wait_drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (index == REG_BASE_PAGE) begin
            base_reg = data;
        end else if (index == REG_CEILING_PAGE) begin
            ceiling_reg = data;
        end
    endtask

    task automatic random_op();
        int unsigned roll;
        int unsigned pick;
        t_frame      fr;
        roll = $urandom_range(99);
        if (roll < 55 || (roll < 90 && held_frames.size() == 0)) begin
            send_req(KIND_ALLOC, t_frame'($urandom));
        end else if (roll < 90) begin
            pick = $urandom_range(held_frames.size() - 1);
            fr   = held_frames[pick];
            held_frames.delete(pick);
            send_req(KIND_FREE, fr);
        end else if (roll < 95) begin
            send_req(KIND_FREE, t_frame'($urandom));
        end else begin
            send_req(KIND_FREE, base_reg + t_frame'($urandom_range(NUM_PAGES - 1)));
        end
    endtask

    task automatic run_phase(input int unsigned gap, input int unsigned stall,
                             input int unsigned count);
        set_phase(gap, stall);
        repeat (count) random_op();
        wait_drain();
    endtask

    task automatic test_first_allocs();
        set_phase(0, 0);
        repeat (10) send_req(KIND_ALLOC, '0);
        wait_drain();
    endtask

    task automatic test_random_no_idle();
        run_phase(0, 0, 85);
    endtask

    task automatic test_random_sender_idle();
        run_phase(52, 0, 85);
    endtask

    task automatic test_random_receiver_stall();
        run_phase(0, 52, 85);
    endtask

    task automatic test_random_both_idle();
        run_phase(22, 22, 85);
    endtask

    task automatic test_free_range();
        set_phase(0, 0);
        write_cfg(REG_BASE_PAGE, 20'd1000);
        send_req(KIND_FREE, 20'd999);
        send_req(KIND_FREE, 20'd33768);
        send_req(KIND_FREE, 20'd33767);
        send_req(KIND_FREE, 20'hFFFFF);
        send_req(KIND_ALLOC, '0);
        send_req(KIND_FREE, 20'd1000);
        write_cfg(REG_BASE_PAGE, '0);
    endtask

    task automatic test_top_base();
        set_phase(0, 0);
        write_cfg(REG_BASE_PAGE, 20'hFFFF8);
        write_cfg(REG_CEILING_PAGE, 20'hFFFFF);
        send_req(KIND_ALLOC, '0);
        send_req(KIND_FREE, 20'hFFFFF);
        send_req(KIND_ALLOC, '0);
        send_req(KIND_FREE, 20'hFFFF8);
        send_req(KIND_ALLOC, '0);
        send_req(KIND_FREE, 20'h00000);
        send_req(KIND_FREE, 20'hFFFF7);
        write_cfg(REG_BASE_PAGE, '0);
        write_cfg(REG_CEILING_PAGE, CEIL_RESET);
    endtask

    task automatic test_double_free();
        t_frame fr;
        set_phase(0, 0);
        send_req(KIND_ALLOC, '0);
        if (held_frames.size() != 0) begin
            fr = held_frames.pop_back();
            send_req(KIND_FREE, fr);
            send_req(KIND_FREE, fr);
        end
        wait_drain();
    endtask

    task automatic test_ceiling();
        set_phase(0, 0);
        write_cfg(REG_CEILING_PAGE, t_frame'({first_free_byte, 3'b000}) + 20'd3);
        repeat (6) send_req(KIND_ALLOC, '0);
        write_cfg(REG_CEILING_PAGE, '0);
        repeat (2) send_req(KIND_ALLOC, '0);
        write_cfg(REG_CEILING_PAGE, CEIL_RESET);
    endtask

    task automatic test_unknown_index();
        set_phase(0, 0);
        write_cfg(REG_SPARE_2, 20'h12345);
        write_cfg(REG_SPARE_3, 20'h00000);
        repeat (4) send_req(KIND_ALLOC, '0);
        wait_drain();
    endtask

    task automatic test_long_scan();
        int unsigned mark;
        t_frame      low_frame;
        set_phase(0, 0);
        repeat (2) begin
            mark = held_frames.size();
            repeat (24) send_req(KIND_ALLOC, '0);
            if (held_frames.size() > mark) begin
                low_frame = held_frames[mark];
                held_frames.delete(mark);
                send_req(KIND_FREE, low_frame);
                send_req(KIND_ALLOC, '0);
            end
        end
        wait_drain();
    endtask

    task automatic test_pressure();
        set_phase(0, 52);
        repeat (12) random_op();
        wait_drain();
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= KIND_ALLOC;
        req_ch.frame <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_BASE_PAGE;
        cfg_ch.data  <= '0;
        req_up = 1'b0;
        model_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_first_allocs();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_free_range();
        test_top_base();
        test_double_free();
        test_ceiling();
        test_unknown_index();
        test_long_scan();
        test_pressure();

        wait_drain();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/bpa_pkg.sv
src/bpa_if.sv
src/bpa_bitmap_ram.sv
src/bitmap_page_allocator_unit.sv
tb/sv/bitmap_page_allocator_unit_test.sv
